FILE: hdl/dlti_pkg.sv
// Shared types and constants for the decimal literal to int32 parser.
// Depends on nothing; every other file of the block imports it.
package dlti_pkg;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Field and register widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int UPPER_W  = 31;
    localparam int MAG_W    = 32;
    localparam int PROD_W   = MAG_W + 4;   // magnitude * 10 + digit
    localparam int CMP_W    = PROD_W + 1;  // signed form of that product
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_LIMIT = 2'd0,
        CFG_LOWER_LIMIT = 2'd1,
        CFG_NULL_CODE   = 2'd2
    } cfg_idx_t;

    // Register reset values
    localparam logic [UPPER_W-1:0] UPPER_RESET = 31'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] LOWER_RESET = 32'h8000_0001;
    localparam logic [VALUE_W-1:0] NULL_RESET  = 32'h8000_0000;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NULL     = 2'd1,
        ST_INVALID  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Per-token parser state
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             negative;
        logic             started;
        logic             digit_seen;
        status_t          error_code;
    } token_t;

    localparam token_t TOKEN_CLEAR = '{
        magnitude:  '0,
        negative:   1'b0,
        started:    1'b0,
        digit_seen: 1'b0,
        error_code: ST_OK
    };

endpackage

FILE: hdl/dlti_char_if.sv
// Character channel: one ASCII byte of a literal per word, with token flags.
// Depends on dlti_pkg for field widths.
interface dlti_char_if
    import dlti_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              last;
    logic              empty_req;

    modport source (output valid, output char_byte, output last, output empty_req,
                    input ready);
    modport sink   (input valid, input char_byte, input last, input empty_req,
                    output ready);
endinterface

FILE: hdl/dlti_result_if.sv
// Result channel: one parsed value and its status per word.
// Depends on dlti_pkg for field widths.
interface dlti_result_if
    import dlti_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: hdl/dlti_step.sv
// Combinational step of the parser: one byte against the token state.
// Depends on dlti_pkg for the token state type and status codes.
module dlti_step
    import dlti_pkg::*;
(
    input  token_t              tok,
    input  logic [CHAR_W-1:0]   char_byte,
    input  logic                last,
    input  logic                empty_req,
    input  logic [UPPER_W-1:0]  upper_limit,
    input  logic [VALUE_W-1:0]  lower_limit,
    input  logic [VALUE_W-1:0]  null_code,
    output token_t              tok_next,
    output logic                res_flag,
    output logic [VALUE_W-1:0]  res_value,
    output status_t             res_status
);

    logic                     take;
    logic                     is_digit;
    logic [3:0]               digit;
    logic [PROD_W-1:0]        prod;
    logic signed [CMP_W-1:0]  signed_val;
    logic signed [CMP_W-1:0]  upper_ext;
    logic signed [CMP_W-1:0]  lower_ext;
    logic                     over;
    token_t                   t;

    // Accumulate magnitude * 10 + digit, and test it against both limits
    assign is_digit  = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
    assign digit     = 4'(char_byte - CHAR_ZERO);
    assign prod      = PROD_W'({tok.magnitude, 3'b000}) + PROD_W'({tok.magnitude, 1'b0})
                       + PROD_W'(digit);
    assign upper_ext = signed'(CMP_W'(upper_limit));
    assign lower_ext = signed'({{(CMP_W-VALUE_W){lower_limit[VALUE_W-1]}}, lower_limit});

    always_comb
    begin
        take       = 1'b0;
        signed_val = '0;
        over       = 1'b0;
        t          = tok;
        res_flag   = 1'b0;
        res_value  = '0;
        res_status = ST_OK;

        if (empty_req)
        begin
            // Drop any token in progress and report the null marker
            t          = TOKEN_CLEAR;
            res_flag   = 1'b1;
            res_value  = null_code;
            res_status = ST_NULL;
        end
        else
        begin
            // A sign counts only as the first byte of a token
            if (!tok.started)
            begin
                t.started = 1'b1;
                if (char_byte == CHAR_MINUS)
                begin
                    t.negative = 1'b1;
                end
                else if (char_byte != CHAR_PLUS)
                begin
                    take = 1'b1;
                end
            end
            else if (tok.error_code == ST_OK)
            begin
                take = 1'b1;
            end

            // Fold in one digit; first error holds
            if (take)
            begin
                if (!is_digit)
                begin
                    t.error_code = ST_INVALID;
                end
                else
                begin
                    t.digit_seen = 1'b1;
                    signed_val = t.negative ? -signed'({1'b0, prod})
                                            : signed'({1'b0, prod});
                    over = (signed_val > upper_ext) || (signed_val < lower_ext);
                    if (over)
                    begin
                        t.error_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        t.magnitude = prod[MAG_W-1:0];
                    end
                end
            end

            // Close the token at its last byte
            if (last)
            begin
                res_flag = 1'b1;
                if (t.error_code == ST_OK && !t.digit_seen)
                begin
                    res_status = ST_INVALID;
                end
                else
                begin
                    res_status = t.error_code;
                end
                if (res_status == ST_OK)
                begin
                    res_value = t.negative ? (VALUE_W'(0) - t.magnitude) : t.magnitude;
                end
                t = TOKEN_CLEAR;
            end
        end

        tok_next = t;
    end

endmodule

FILE: hdl/decimal_literal_to_int32.sv
// Top level of the decimal literal to int32 parser: input register, token
// state, result register. Depends on dlti_pkg, dlti_char_if, dlti_result_if, dlti_step.
//
// Takes one ASCII byte per word and gives one result word per token, at its
// last byte or at once for a word flagged as an empty token. One word is
// accepted every clock cycle unless a result is held back by a full output. The
// combinational accumulate step (magnitude * 10 + digit with the limit compare)
// sits between the input register and the result register. Words that give no
// result keep moving while a result waits to be taken. The limit and null-code
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the parser is idle, which the block itself does not enforce;
// index 0 is the upper limit, 1 the lower limit, 2 the null code.
module decimal_literal_to_int32
    import dlti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dlti_char_if.sink             char_in,
    dlti_result_if.source         result_out
);

    logic [UPPER_W-1:0]  upper_limit_reg;
    logic [VALUE_W-1:0]  lower_limit_reg;
    logic [VALUE_W-1:0]  null_code_reg;

    logic                item_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;
    logic                empty_reg;

    token_t              tok_reg;
    token_t              tok_next;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg;
    status_t             status_reg;

    logic                res_flag;
    logic [VALUE_W-1:0]  res_value;
    status_t             res_status;
    logic                advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_limit_reg <= UPPER_RESET;
            lower_limit_reg <= LOWER_RESET;
            null_code_reg   <= NULL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UPPER_LIMIT: upper_limit_reg <= cfg_data[UPPER_W-1:0];
                CFG_LOWER_LIMIT: lower_limit_reg <= cfg_data[VALUE_W-1:0];
                CFG_NULL_CODE:   null_code_reg   <= cfg_data[VALUE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Parse step on the registered word
    dlti_step u_step (
        .tok         (tok_reg),
        .char_byte   (char_reg),
        .last        (last_reg),
        .empty_req   (empty_reg),
        .upper_limit (upper_limit_reg),
        .lower_limit (lower_limit_reg),
        .null_code   (null_code_reg),
        .tok_next    (tok_next),
        .res_flag    (res_flag),
        .res_value   (res_value),
        .res_status  (res_status)
    );

    // Advance the held word unless its result would land on a full output
    assign advance       = item_valid_reg &&
                           (!res_flag || !out_valid_reg || result_out.ready);
    assign char_in.ready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            item_valid_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            char_reg  <= char_in.char_byte;
            last_reg  <= char_in.last;
            empty_reg <= char_in.empty_req;
        end
    end

    // Token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= TOKEN_CLEAR;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_flag)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_flag)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
        end
    end

    assign result_out.valid  = out_valid_reg;
    assign result_out.value  = value_reg;
    assign result_out.status = status_reg;

endmodule
